// File: hw/rtl/brb_pkg.sv
// Shared types and codes for the byte ring buffer.
package brb_pkg;

    localparam int PTR_W  = 8;
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 9;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_SKIP  = 2'd2,
        FN_QUERY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_REJECT = 2'd1,
        STS_DROP   = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // ring memory request from the controller
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } mem_req_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic [PTR_W-1:0]  block_offset;
        logic [PTR_W-1:0]  block_len;
        logic [PTR_W-1:0]  fill_level;
    } result_t;

endpackage

// File: hw/rtl/brb_ram.sv
// Byte storage of the ring: one write port, one registered read port.
module brb_ram #(
    parameter int MEM_DEPTH = 256
) (
    input  logic                       clk,
    input  brb_pkg::mem_req_t          req,
    output logic [brb_pkg::BYTE_W-1:0] rd_data
);
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [brb_pkg::BYTE_W-1:0] mem [MEM_DEPTH];
    logic [brb_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/brb_ctrl.sv
// Pointer state, message tracking and read sequencing of the ring buffer.
module brb_ctrl #(
    parameter int SIZE_CAP = 256,
    parameter int READ_MAX = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [brb_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic                       first,
    input  logic [brb_pkg::PTR_W-1:0]  length,
    input  logic [brb_pkg::BYTE_W-1:0] data_byte,
    input  logic                       out_free,
    output logic                       res_load,
    output brb_pkg::result_t           res,
    output brb_pkg::mem_req_t          mem_req,
    input  logic [brb_pkg::BYTE_W-1:0] mem_rd_data
);
    localparam int CW = $clog2(READ_MAX + 1);
    localparam logic [brb_pkg::SIZE_W-1:0] CAP = brb_pkg::SIZE_W'(SIZE_CAP);
    localparam logic [brb_pkg::PTR_W-1:0]  RMAX = brb_pkg::PTR_W'(READ_MAX);

    brb_pkg::state_t             state_reg, state_next;
    logic [brb_pkg::SIZE_W-1:0]  bsize_reg;
    logic [brb_pkg::PTR_W-1:0]   head_reg, head_next;
    logic [brb_pkg::PTR_W-1:0]   tail_reg, tail_next;
    logic [brb_pkg::PTR_W-1:0]   pwi_reg, pwi_next;
    logic [brb_pkg::PTR_W-1:0]   prem_reg, prem_next;
    logic                        pacc_reg, pacc_next;
    logic [CW-1:0]               rd_cnt_reg, rd_cnt_next;
    logic [brb_pkg::PTR_W-1:0]   fill_after_reg, fill_after_next;

    logic [brb_pkg::SIZE_W-1:0]  size_eff;
    logic [brb_pkg::PTR_W-1:0]   fill_now;
    logic [brb_pkg::SIZE_W-1:0]  room;
    logic [brb_pkg::PTR_W-1:0]   n_sel;
    logic [brb_pkg::SIZE_W-1:0]  skip_sum;
    logic                        accept;

    function automatic logic [brb_pkg::PTR_W-1:0] calc_fill(
        input logic [brb_pkg::PTR_W-1:0]  h,
        input logic [brb_pkg::PTR_W-1:0]  t,
        input logic [brb_pkg::SIZE_W-1:0] s
    );
        logic [brb_pkg::SIZE_W-1:0] d;
        if (h >= t)
            d = {1'b0, h} - {1'b0, t};
        else
            d = s - ({1'b0, t} - {1'b0, h});
        return d[brb_pkg::PTR_W-1:0];
    endfunction

    function automatic logic [brb_pkg::PTR_W-1:0] ptr_inc(
        input logic [brb_pkg::PTR_W-1:0]  p,
        input logic [brb_pkg::SIZE_W-1:0] s
    );
        logic [brb_pkg::SIZE_W-1:0] q;
        q = {1'b0, p} + 9'd1;
        if (q == s)
            q = '0;
        return q[brb_pkg::PTR_W-1:0];
    endfunction

    // effective ring size, clamped to [2, cap]
    always_comb
    begin
        if (bsize_reg < 9'd2)
            size_eff = 9'd2;
        else if (bsize_reg > CAP)
            size_eff = CAP;
        else
            size_eff = bsize_reg;
    end

    assign fill_now = calc_fill(head_reg, tail_reg, size_eff);
    assign room     = (size_eff - 9'd1) - {1'b0, fill_now};
    assign in_ready = (state_reg == brb_pkg::S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // min(fill, length), shared by read and skip
    assign n_sel    = (length < fill_now) ? length : fill_now;
    assign skip_sum = {1'b0, tail_reg} + {1'b0, n_sel};

    always_comb
    begin
        logic [brb_pkg::PTR_W-1:0] rd_n;

        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        pwi_next        = pwi_reg;
        prem_next       = prem_reg;
        pacc_next       = pacc_reg;
        rd_cnt_next     = rd_cnt_reg;
        fill_after_next = fill_after_reg;
        res_load        = 1'b0;
        res             = '0;
        res.last        = 1'b1;
        mem_req         = '0;
        rd_n            = (n_sel > RMAX) ? RMAX : n_sel;

        unique case (state_reg)
            brb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    unique case (brb_pkg::func_t'(func))
                        brb_pkg::FN_WRITE:
                        begin
                            logic store;
                            store = 1'b0;
                            res.status = brb_pkg::STS_OK;
                            if (first)
                            begin
                                prem_next = '0;
                                pacc_next = 1'b0;
                                if (length == '0)
                                begin
                                    res.status = brb_pkg::STS_OK;
                                end
                                else if ({1'b0, length} > room)
                                begin
                                    prem_next  = length - 8'd1;
                                    res.status = brb_pkg::STS_REJECT;
                                end
                                else
                                begin
                                    pacc_next = 1'b1;
                                    pwi_next  = head_reg;
                                    prem_next = length;
                                    store     = 1'b1;
                                end
                            end
                            else if (prem_reg == '0)
                            begin
                                res.status = brb_pkg::STS_DROP;
                            end
                            else if (!pacc_reg)
                            begin
                                prem_next  = prem_reg - 8'd1;
                                res.status = brb_pkg::STS_DROP;
                            end
                            else
                            begin
                                store = 1'b1;
                            end

                            if (store)
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = pwi_next;
                                mem_req.wr_data = data_byte;
                                pwi_next        = ptr_inc(pwi_next, size_eff);
                                prem_next       = prem_next - 8'd1;
                                if (prem_next == '0)
                                begin
                                    head_next = pwi_next;
                                    pacc_next = 1'b0;
                                end
                            end
                            res.fill_level = calc_fill(head_next, tail_reg, size_eff);
                        end

                        brb_pkg::FN_READ:
                        begin
                            if (rd_n == '0)
                            begin
                                res.fill_level = fill_now;
                            end
                            else
                            begin
                                // results come out of the read loop instead
                                res_load        = 1'b0;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = tail_reg;
                                rd_cnt_next     = rd_n[CW-1:0];
                                fill_after_next = fill_now - rd_n;
                                state_next      = brb_pkg::S_READ;
                            end
                        end

                        brb_pkg::FN_SKIP:
                        begin
                            if (skip_sum >= size_eff)
                                tail_next = 8'(skip_sum - size_eff);
                            else
                                tail_next = skip_sum[brb_pkg::PTR_W-1:0];
                            res.fill_level = fill_now - n_sel;
                        end

                        brb_pkg::FN_QUERY:
                        begin
                            res.block_offset = tail_reg;
                            if (head_reg >= tail_reg)
                                res.block_len = head_reg - tail_reg;
                            else
                                res.block_len = 8'(size_eff - {1'b0, tail_reg});
                            res.fill_level = fill_now;
                        end

                        default:
                        begin
                            res.fill_level = fill_now;
                        end
                    endcase
                end
            end

            brb_pkg::S_READ:
            begin
                // memory data for tail_reg is ready; fetch next while emitting
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res.status     = brb_pkg::STS_OK;
                    res.out_byte   = mem_rd_data;
                    res.byte_valid = 1'b1;
                    res.last       = (rd_cnt_reg == CW'(1));
                    res.fill_level = fill_after_reg;
                    tail_next      = ptr_inc(tail_reg, size_eff);
                    rd_cnt_next    = rd_cnt_reg - CW'(1);
                    if (rd_cnt_reg == CW'(1))
                    begin
                        state_next = brb_pkg::S_IDLE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = tail_next;
                    end
                end
            end

            default:
            begin
                state_next = brb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= brb_pkg::S_IDLE;
            bsize_reg      <= 9'd256;
            head_reg       <= '0;
            tail_reg       <= '0;
            pwi_reg        <= '0;
            prem_reg       <= '0;
            pacc_reg       <= 1'b0;
            rd_cnt_reg     <= '0;
            fill_after_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            bsize_reg <= cfg_wr_data;
            head_reg  <= '0;
            tail_reg  <= '0;
            pwi_reg   <= '0;
            prem_reg  <= '0;
            pacc_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            pwi_reg        <= pwi_next;
            prem_reg       <= prem_next;
            pacc_reg       <= pacc_next;
            rd_cnt_reg     <= rd_cnt_next;
            fill_after_reg <= fill_after_next;
        end
    end

    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brb_pkg::S_READ) |-> !in_ready)
        else $error("input taken during read burst");

    a_read_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brb_pkg::S_READ) |-> (rd_cnt_reg != '0))
        else $error("read burst with zero count");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded into occupied output stage");

    a_pending_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pacc_reg |-> (prem_reg != '0))
        else $error("accepting message with nothing remaining");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, head_reg} < size_eff) && ({1'b0, tail_reg} < size_eff))
        else $error("pointer outside ring");

endmodule

// File: hw/rtl/byte_ring_buffer.sv
// Top level of the byte ring FIFO: controller, ring memory, output stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | func, first, length, data_byte
//  out     | output    | out_valid / out_ready| status, out_byte, byte_valid, last,
//          |           |                      | block_offset, block_len, fill_level
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (buffer_size)
//
// Write, skip, query and empty read: one result per transaction.
// A read of n bytes (n <= READ_MAX) first waits on the registered memory read, then
//   delivers one byte per cycle off the single read port while out_ready is held high.
// Reset (rst_n low, async) sets buffer_size to 256 and clears all pointers; the
//   ring memory is not cleared since only committed bytes are ever read.
// in_ready drops during a read burst and whenever the output stage holds a
//   result that is not being taken; out_ready low stalls the burst in place.
module byte_ring_buffer #(
    parameter int DEPTH    = 256,
    parameter int READ_MAX = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [brb_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic                       first,
    input  logic [7:0]                 length,
    input  logic [7:0]                 data_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [7:0]                 out_byte,
    output logic                       byte_valid,
    output logic                       last,
    output logic [7:0]                 block_offset,
    output logic [7:0]                 block_len,
    output logic [7:0]                 fill_level
);
    // ring never exceeds 256 slots, whatever DEPTH says
    localparam int MEM_DEPTH = (DEPTH < 256) ? DEPTH : 256;

    brb_pkg::mem_req_t           mem_req;
    logic [brb_pkg::BYTE_W-1:0]  mem_rd_data;
    brb_pkg::result_t            res;
    logic                        res_load;
    logic                        out_free;

    logic                        out_valid_reg;
    brb_pkg::result_t            out_res_reg;

    // output stage is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    brb_ctrl #(
        .SIZE_CAP (MEM_DEPTH),
        .READ_MAX (READ_MAX)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .first       (first),
        .length      (length),
        .data_byte   (data_byte),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    brb_ram #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // result register: one transaction held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign out_byte     = out_res_reg.out_byte;
    assign byte_valid   = out_res_reg.byte_valid;
    assign last         = out_res_reg.last;
    assign block_offset = out_res_reg.block_offset;
    assign block_len    = out_res_reg.block_len;
    assign fill_level   = out_res_reg.fill_level;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the byte ring buffer: directed and random traffic against a predictor.
module tb;

    localparam int READ_LIMIT  = 64;    // bytes per read transaction
    localparam int STALL_LIMIT = 4000;  // cycles with no transaction before giving up
    localparam int LONG_HOLD   = 400;   // receiver hold-off that backs the block up
    localparam int DRAIN_WAIT  = 80;    // extra wait once everything has drained

    typedef struct {
        brb_pkg::func_t fn;
        logic           fst;
        logic [7:0]     len;
        logic [7:0]     data;
    } ring_op_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [brb_pkg::SIZE_W-1:0] cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [1:0]                 func = brb_pkg::FN_WRITE;
    logic                       first = 1'b0;
    logic [7:0]                 length = '0;
    logic [7:0]                 data_byte = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [1:0]                 status;
    logic [7:0]                 out_byte;
    logic                       byte_valid;
    logic                       last;
    logic [7:0]                 block_offset;
    logic [7:0]                 block_len;
    logic [7:0]                 fill_level;

    byte_ring_buffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .first        (first),
        .length       (length),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .last         (last),
        .block_offset (block_offset),
        .block_len    (block_len),
        .fill_level   (fill_level)
    );

    // ring state as the block should hold it
    logic [7:0]  ring_bytes [0:255];
    int          head_ptr = 0;
    int          tail_ptr = 0;
    int          wr_ptr = 0;
    int          msg_left = 0;
    bit          msg_taking = 1'b0;
    logic [8:0]  size_reg = 9'd256;

    ring_op_t          pending_ops [$];
    brb_pkg::result_t  expected_results [$];
    ring_op_t          cur_op;
    brb_pkg::result_t  next_want;
    int          pushed_cnt = 0;
    int          accepted_cnt = 0;
    int          err_cnt = 0;
    int          stall_cycles = 0;
    bit          in_taken = 1'b0;

    // traffic shaping
    bit          tx_idle = 1'b1;
    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_mode = 1;
    logic [15:0] rx_pattern = 16'b1110_1101_1111_0011;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_err(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic int ring_slots();
        if (size_reg < 9'd2)
            return 2;
        if (size_reg > 9'd256)
            return 256;
        return int'(size_reg);
    endfunction

    function automatic int ring_fill(int s);
        return (head_ptr >= tail_ptr) ? head_ptr - tail_ptr : s - (tail_ptr - head_ptr);
    endfunction

    task automatic load_ring_size(logic [8:0] v);
        size_reg   = v;
        head_ptr   = 0;
        tail_ptr   = 0;
        wr_ptr     = 0;
        msg_left   = 0;
        msg_taking = 1'b0;
    endtask

    // One write-byte item. The message only becomes readable when its last byte lands.
    function automatic brb_pkg::status_t take_write_byte(int s, logic fst, int len,
                                                         logic [7:0] b);
        if (fst) begin
            msg_left   = 0;
            msg_taking = 1'b0;
            if (len == 0)
                return brb_pkg::STS_OK;
            if (len > (s - 1) - ring_fill(s)) begin
                msg_left = len - 1;     // the rest of the message gets dropped
                return brb_pkg::STS_REJECT;
            end
            msg_taking = 1'b1;
            wr_ptr     = head_ptr;
            msg_left   = len;
        end
        else if (msg_left == 0) begin
            return brb_pkg::STS_DROP;
        end
        else if (!msg_taking) begin
            msg_left--;
            return brb_pkg::STS_DROP;
        end
        ring_bytes[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % s;
        msg_left--;
        if (msg_left == 0) begin
            head_ptr   = wr_ptr;
            msg_taking = 1'b0;
        end
        return brb_pkg::STS_OK;
    endfunction

    // Work out every result one accepted transaction causes.
    task automatic model_ring_op(ring_op_t op);
        brb_pkg::result_t step_res [$];
        brb_pkg::result_t r;
        int      s;
        int      n;
        int      i;
        s = ring_slots();
        r = '0;
        r.last = 1'b1;
        unique case (op.fn)
            brb_pkg::FN_WRITE:
            begin
                r.status = take_write_byte(s, op.fst, op.len, op.data);
                step_res.push_back(r);
            end
            brb_pkg::FN_READ:
            begin
                n = ring_fill(s);
                if (op.len < n)
                    n = op.len;
                if (n > READ_LIMIT)
                    n = READ_LIMIT;
                if (n == 0)
                    step_res.push_back(r);
                for (i = 0; i < n; i++)
                begin
                    r.out_byte   = ring_bytes[tail_ptr];
                    r.byte_valid = 1'b1;
                    r.last       = (i == n - 1);
                    step_res.push_back(r);
                    tail_ptr = (tail_ptr + 1) % s;
                end
            end
            brb_pkg::FN_SKIP:
            begin
                n = ring_fill(s);
                if (op.len < n)
                    n = op.len;
                tail_ptr = (tail_ptr + n) % s;
                step_res.push_back(r);
            end
            default:
            begin
                r.block_offset = 8'(tail_ptr);
                r.block_len    = (head_ptr >= tail_ptr) ? 8'(head_ptr - tail_ptr)
                                                        : 8'(s - tail_ptr);
                step_res.push_back(r);
            end
        endcase
        // every result carries the level after the whole transaction
        foreach (step_res[k])
        begin
            step_res[k].fill_level = 8'(ring_fill(s));
            expected_results.push_back(step_res[k]);
        end
    endtask

    task automatic put_item(brb_pkg::func_t f, logic fst, int len, int d);
        ring_op_t op;
        op.fn   = f;
        op.fst  = fst;
        op.len  = 8'(len);
        op.data = 8'(d);
        pending_ops.push_back(op);
        pushed_cnt++;
    endtask

    // Mostly complete messages with random content, plus reads, skips, queries,
    // cut-short messages, oversize or empty messages and stray bytes.
    task automatic add_random(int n, int max_len);
        int added;
        int pick;
        int len;
        int cut;
        int k;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                len = $urandom_range(1, max_len);
                cut = len;
                if (pick >= 42 && len > 1)
                    cut = $urandom_range(1, len - 1);
                put_item(brb_pkg::FN_WRITE, 1'b1, len, $urandom_range(0, 255));
                for (k = 1; k < cut; k++)
                    put_item(brb_pkg::FN_WRITE, 1'b0, $urandom_range(0, 255),
                             $urandom_range(0, 255));
                added += cut;
            end
            else if (pick < 56) begin
                len = (pick == 50) ? 0 : $urandom_range(max_len + 1, 255);
                put_item(brb_pkg::FN_WRITE, 1'b1, len, $urandom_range(0, 255));
                cut = $urandom_range(0, 2);
                for (k = 0; k < cut; k++)
                    put_item(brb_pkg::FN_WRITE, 1'b0, $urandom_range(0, 255),
                             $urandom_range(0, 255));
                added += 1 + cut;
            end
            else if (pick < 72) begin
                len = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, max_len + 2);
                put_item(brb_pkg::FN_READ, $urandom_range(0, 1), len, $urandom_range(0, 255));
                added++;
            end
            else if (pick < 80) begin
                len = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 3);
                put_item(brb_pkg::FN_SKIP, $urandom_range(0, 1), len, $urandom_range(0, 255));
                added++;
            end
            else if (pick < 90) begin
                put_item(brb_pkg::FN_QUERY, $urandom_range(0, 1), $urandom_range(0, 255),
                         $urandom_range(0, 255));
                added++;
            end
            else begin
                put_item(brb_pkg::FN_WRITE, 1'b0, $urandom_range(0, 255),
                         $urandom_range(0, 255));
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (accepted_cnt != pushed_cnt || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // The size register is only written once every result is back.
    task automatic start_phase(logic [8:0] sz, int rxm, bit txi);
        wait_drained();
        repeat (8) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sz;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        rx_mode   = rxm;
        tx_idle   = txi;
    endtask

    // Sender: bursts of transactions, separated by random gaps when tx_idle is set.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() > 0) begin
                cur_op = pending_ops.pop_front();
                func      <= cur_op.fn;
                first     <= cur_op.fst;
                length    <= cur_op.len;
                data_byte <= cur_op.data;
                in_valid  <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = tx_idle ? $urandom_range(1, 6) : 0;
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: always ready, random stalls, or a rotating pattern; long hold on request.
    always @(negedge clk)
    begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_mode == 0) begin
            out_ready <= 1'b1;
        end
        else if (rx_mode == 1) begin
            out_ready <= ($urandom_range(0, 9) >= 3);
        end
        else begin
            rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
            out_ready <= rx_pattern[0];
        end
    end

    // Predict on accepted inputs first, so a same-edge result still finds its expectation.
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (cfg_wr_en)
                load_ring_size(cfg_wr_data);
            if (in_taken) begin
                accepted_cnt++;
                cur_op.fn   = brb_pkg::func_t'(func);
                cur_op.fst  = first;
                cur_op.len  = length;
                cur_op.data = data_byte;
                model_ring_op(cur_op);
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_err("result with nothing expected", out_byte, 0);
                end
                else begin
                    next_want = expected_results.pop_front();
                    if (status !== next_want.status)
                        report_err("status", status, next_want.status);
                    if (out_byte !== next_want.out_byte)
                        report_err("out_byte", out_byte, next_want.out_byte);
                    if (byte_valid !== next_want.byte_valid)
                        report_err("byte_valid", byte_valid, next_want.byte_valid);
                    if (last !== next_want.last)
                        report_err("last", last, next_want.last);
                    if (block_offset !== next_want.block_offset)
                        report_err("block_offset", block_offset, next_want.block_offset);
                    if (block_len !== next_want.block_len)
                        report_err("block_len", block_len, next_want.block_len);
                    if (fill_level !== next_want.fill_level)
                        report_err("fill_level", fill_level, next_want.fill_level);
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset size: empty-ring corners, stray and zero-length writes, abandoned message
        put_item(brb_pkg::FN_QUERY, 1'b0, 0, 0);
        put_item(brb_pkg::FN_READ, 1'b0, 5, 0);
        put_item(brb_pkg::FN_SKIP, 1'b1, 255, 255);
        put_item(brb_pkg::FN_WRITE, 1'b0, 255, 255);
        put_item(brb_pkg::FN_WRITE, 1'b1, 0, 8'h5a);
        put_item(brb_pkg::FN_WRITE, 1'b1, 3, 8'h00);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'hff);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'ha5);
        put_item(brb_pkg::FN_WRITE, 1'b1, 4, 8'h11);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'h22);
        put_item(brb_pkg::FN_WRITE, 1'b1, 2, 8'h33);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'h44);
        put_item(brb_pkg::FN_QUERY, 1'b1, 255, 255);
        put_item(brb_pkg::FN_READ, 1'b0, 2, 0);
        put_item(brb_pkg::FN_SKIP, 1'b0, 255, 0);
        put_item(brb_pkg::FN_READ, 1'b0, 0, 0);
        put_item(brb_pkg::FN_QUERY, 1'b0, 0, 0);

        // four slots: rejected message and its dropped tail, then a full ring
        start_phase(9'd4, 1, 1'b1);
        put_item(brb_pkg::FN_WRITE, 1'b1, 4, 8'h01);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'h02);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'h03);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'h04);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'h05);
        put_item(brb_pkg::FN_WRITE, 1'b1, 3, 8'hc0);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'hc1);
        put_item(brb_pkg::FN_WRITE, 1'b0, 0, 8'hc2);
        put_item(brb_pkg::FN_READ, 1'b0, 255, 0);
        add_random(15, 4);

        // below the minimum: clamps to two slots
        start_phase(9'd0, 2, 1'b1);
        add_random(10, 2);

        // above the maximum: one long message, then a read capped at READ_LIMIT
        start_phase(9'd511, 0, 1'b0);
        put_item(brb_pkg::FN_WRITE, 1'b1, 70, $urandom_range(0, 255));
        for (int k = 1; k < 70; k++)
            put_item(brb_pkg::FN_WRITE, 1'b0, $urandom_range(0, 255), $urandom_range(0, 255));
        put_item(brb_pkg::FN_READ, 1'b0, 255, 0);
        put_item(brb_pkg::FN_QUERY, 1'b0, 0, 0);
        put_item(brb_pkg::FN_READ, 1'b0, 255, 0);
        add_random(5, 12);

        // long receiver hold while the sender keeps pushing
        start_phase(9'd17, 1, 1'b1);
        hold_req++;
        add_random(20, 8);

        start_phase(9'd256, 2, 1'b0);
        add_random(8, 16);

        start_phase(9'd3, 1, 1'b1);
        add_random(10, 3);

        start_phase(9'd100, 0, 1'b1);
        add_random(10, 10);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (expected_results.size() != 0)
            report_err("results never arrived", expected_results.size(), 0);
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: byte_ring_buffer.f
hw/rtl/brb_pkg.sv
hw/rtl/brb_ram.sv
hw/rtl/brb_ctrl.sv
hw/rtl/byte_ring_buffer.sv
dv/tb.sv
